>>> rtl/dfcl_pkg.sv
// dfcl_pkg: types, codes and constants shared by the sector chain loader
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package dfcl_pkg;

    localparam int SECTOR_BYTES = 128;
    localparam int WORD_BYTES   = 4;
    localparam int WORDS        = SECTOR_BYTES / WORD_BYTES;
    localparam int WORD_AW      = $clog2(WORDS);

    // sector trailer handling
    localparam logic [7:0] BYTE_CNT_MASK = 8'h7F;
    localparam logic [7:0] LINK_HI_MASK  = 8'h03;
    localparam logic [6:0] MAX_USED      = 7'd125;
    localparam logic [7:0] OK_CODE       = 8'h01;

    // command codes
    localparam logic [1:0] CMD_OPEN = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_FAIL = 2'd2;

    // status codes
    localparam logic [2:0] STAT_NEXT     = 3'd0;
    localparam logic [2:0] STAT_DONE     = 3'd1;
    localparam logic [2:0] STAT_READ_ERR = 3'd2;
    localparam logic [2:0] STAT_BAD_LINK = 3'd3;
    localparam logic [2:0] STAT_TOO_BIG  = 3'd4;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one unit of back-end work: optional data words, then one status
    typedef struct packed {
        logic        uses_store;
        logic [6:0]  byte_cnt;
        logic [15:0] base;
        logic [2:0]  st;
        logic [15:0] next_sector;
        logic [15:0] total;
        logic [15:0] sectors;
        logic [15:0] failing;
        logic [7:0]  code;
    } job_t;

    // sector store write port, front to back
    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        logic [31:0]        data;
    } wr_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic [15:0] dest_offset;
        logic [2:0]  status;
        logic [15:0] next_sector;
        logic [15:0] total_bytes;
        logic [15:0] sectors_done;
        logic [15:0] failing_sector;
        logic [7:0]  failure_code;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/dfcl_ifs.sv
// dfcl_cmd_if and dfcl_res_if: valid/ready channels of the chain loader
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dfcl_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic        link16_mode;
    logic [5:0]  file_number;
    logic [15:0] start_sector;
    logic [15:0] max_length;
    logic [31:0] sector_word;
    logic [7:0]  read_status;

    modport source (output valid, command, link16_mode, file_number, start_sector,
                    max_length, sector_word, read_status, input ready);
    modport sink   (input valid, command, link16_mode, file_number, start_sector,
                    max_length, sector_word, read_status, output ready);
endinterface

interface dfcl_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic [15:0] dest_offset;
    logic [2:0]  status;
    logic [15:0] next_sector;
    logic [15:0] total_bytes;
    logic [15:0] sectors_done;
    logic [15:0] failing_sector;
    logic [7:0]  failure_code;
    logic        last;

    modport source (output valid, kind, data_word, valid_bytes, dest_offset, status,
                    next_sector, total_bytes, sectors_done, failing_sector,
                    failure_code, last, input ready);
    modport sink   (input valid, kind, data_word, valid_bytes, dest_offset, status,
                    next_sector, total_bytes, sectors_done, failing_sector,
                    failure_code, last, output ready);
endinterface

`default_nettype wire

>>> rtl/dfcl_front.sv
// dfcl_front: accepts requests, tracks the open file, checks sector trailers
// depends on dfcl_pkg and dfcl_cmd_if
`timescale 1ns / 1ps
`default_nettype none

module dfcl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dfcl_cmd_if.sink           cmd,
    input  wire logic          q_full,
    input  wire logic          sector_done,
    output logic               push,
    output dfcl_pkg::job_t     job,
    output dfcl_pkg::wr_t      wr
);
    import dfcl_pkg::*;

    logic [WORD_AW-1:0] word_index_reg, word_index_next;
    logic [15:0]        current_sector_reg, current_sector_next;
    logic [15:0]        bytes_so_far_reg, bytes_so_far_next;
    logic [15:0]        sector_count_reg, sector_count_next;
    logic               wide_links_reg, wide_links_next;
    logic [5:0]         expected_file_reg, expected_file_next;
    logic [15:0]        capacity_reg, capacity_next;
    logic               active_reg, active_next;
    logic               sec_pending_reg, sec_pending_next;

    logic               accept;
    logic [7:0]         link_hi;
    logic [7:0]         link_lo;
    logic [6:0]         used_cnt;
    logic [16:0]        sum17;
    logic [15:0]        next_link;
    logic [15:0]        sc_inc;
    logic               file_bad;
    logic               cnt_bad;
    logic               too_big;

    // requests wait while the job queue is full or the back end still reads the store
    assign cmd.ready = !q_full && !sec_pending_reg;
    assign accept    = cmd.valid && cmd.ready;

    // trailer lives in the last word: bytes 125, 126, 127
    assign link_hi  = cmd.sector_word[15:8];
    assign link_lo  = cmd.sector_word[23:16];
    assign used_cnt = 7'(cmd.sector_word[31:24] & BYTE_CNT_MASK);
    assign sum17    = {1'b0, bytes_so_far_reg} + 17'(used_cnt);
    assign too_big  = sum17 > {1'b0, capacity_reg};
    assign file_bad = !wide_links_reg && (link_hi[7:2] != expected_file_reg);
    assign cnt_bad  = used_cnt > MAX_USED;
    assign sc_inc   = (sector_count_reg == 16'hFFFF) ? sector_count_reg
                                                     : sector_count_reg + 16'd1;
    assign next_link = wide_links_reg ? {link_hi, link_lo}
                                      : {link_hi & LINK_HI_MASK, link_lo};

    always_comb
    begin
        word_index_next     = word_index_reg;
        current_sector_next = current_sector_reg;
        bytes_so_far_next   = bytes_so_far_reg;
        sector_count_next   = sector_count_reg;
        wide_links_next     = wide_links_reg;
        expected_file_next  = expected_file_reg;
        capacity_next       = capacity_reg;
        active_next         = active_reg;
        push                = 1'b0;
        job                 = '0;
        job.code            = OK_CODE;
        wr.en               = 1'b0;
        wr.addr             = word_index_reg;
        wr.data             = cmd.sector_word;

        case (cmd.command)
            CMD_OPEN:
            begin
                if (accept)
                begin
                    wide_links_next     = cmd.link16_mode;
                    expected_file_next  = cmd.file_number;
                    current_sector_next = cmd.start_sector;
                    capacity_next       = cmd.max_length;
                    bytes_so_far_next   = '0;
                    sector_count_next   = '0;
                    word_index_next     = '0;
                    push                = 1'b1;
                    if (cmd.start_sector == 16'd0)
                    begin
                        active_next = 1'b0;
                        job.st      = STAT_DONE;
                    end
                    else
                    begin
                        active_next     = 1'b1;
                        job.st          = STAT_NEXT;
                        job.next_sector = cmd.start_sector;
                    end
                end
            end
            CMD_DATA:
            begin
                if (accept && active_reg)
                begin
                    wr.en           = 1'b1;
                    word_index_next = word_index_reg + 1'b1;
                    if (word_index_reg == WORD_AW'(WORDS - 1))
                    begin
                        sector_count_next = sc_inc;
                        push              = 1'b1;
                        job.sectors       = sc_inc;
                        job.total         = bytes_so_far_reg;
                        if (file_bad || cnt_bad)
                        begin
                            active_next = 1'b0;
                            job.st      = STAT_BAD_LINK;
                            job.failing = current_sector_reg;
                        end
                        else if (too_big)
                        begin
                            active_next = 1'b0;
                            job.st      = STAT_TOO_BIG;
                        end
                        else
                        begin
                            job.uses_store    = 1'b1;
                            job.byte_cnt      = used_cnt;
                            job.base          = bytes_so_far_reg;
                            job.total         = sum17[15:0];
                            bytes_so_far_next = sum17[15:0];
                            if (next_link == 16'd0)
                            begin
                                active_next = 1'b0;
                                job.st      = STAT_DONE;
                            end
                            else
                            begin
                                current_sector_next = next_link;
                                job.st              = STAT_NEXT;
                                job.next_sector     = next_link;
                            end
                        end
                    end
                end
            end
            CMD_FAIL:
            begin
                if (accept && active_reg)
                begin
                    word_index_next = '0;
                    active_next     = 1'b0;
                    push            = 1'b1;
                    job.st          = STAT_READ_ERR;
                    job.failing     = current_sector_reg;
                    job.code        = cmd.read_status;
                    job.total       = bytes_so_far_reg;
                    job.sectors     = sector_count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sec_pending_next = sec_pending_reg;
        if (push && job.uses_store)
            sec_pending_next = 1'b1;
        else if (sector_done)
            sec_pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg     <= '0;
            current_sector_reg <= '0;
            bytes_so_far_reg   <= '0;
            sector_count_reg   <= '0;
            wide_links_reg     <= 1'b0;
            expected_file_reg  <= '0;
            capacity_reg       <= '0;
            active_reg         <= 1'b0;
            sec_pending_reg    <= 1'b0;
        end
        else
        begin
            word_index_reg     <= word_index_next;
            current_sector_reg <= current_sector_next;
            bytes_so_far_reg   <= bytes_so_far_next;
            sector_count_reg   <= sector_count_next;
            wide_links_reg     <= wide_links_next;
            expected_file_reg  <= expected_file_next;
            capacity_reg       <= capacity_next;
            active_reg         <= active_next;
            sec_pending_reg    <= sec_pending_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dfcl_queue.sv
// dfcl_queue: short job queue between front and back
// depends on dfcl_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfcl_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  dfcl_pkg::job_t      push_job,
    input  wire logic           pop,
    output dfcl_pkg::job_t      head,
    output logic                full,
    output logic                empty
);
    import dfcl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dfcl_back.sv
// dfcl_back: sector store, job sequencer and two-stage result pipeline
// depends on dfcl_pkg and dfcl_res_if
`timescale 1ns / 1ps
`default_nettype none

module dfcl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  dfcl_pkg::wr_t      wr,
    input  wire logic          q_empty,
    input  dfcl_pkg::job_t     q_head,
    output logic               q_pop,
    output logic               sector_done,
    dfcl_res_if.source         res
);
    import dfcl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } bstate_t;

    logic [31:0]        store [WORDS];
    bstate_t            state_reg, state_next;
    job_t               job_reg;
    logic [7:0]         k_reg, k_next;
    logic               s1_valid_reg, s1_valid_next;
    res_t               s1_reg;
    logic [31:0]        rdata_reg;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg;

    logic               adv;
    logic               s1_free;
    logic               issue;
    logic               more_data;
    logic [7:0]         remain;
    logic [2:0]         nv;
    logic [15:0]        data_off;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    res_t               item;
    res_t               out_item;

    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    assign adv       = !out_valid_reg || res.ready;
    assign s1_free   = !s1_valid_reg || adv;
    assign issue     = (state_reg == S_RUN) && s1_free;
    assign more_data = k_reg < {1'b0, job_reg.byte_cnt};
    assign remain    = {1'b0, job_reg.byte_cnt} - k_reg;
    assign nv        = (remain >= 8'(WORD_BYTES)) ? 3'(WORD_BYTES) : remain[2:0];
    assign data_off  = job_reg.base + 16'(k_reg);
    assign rd_en     = issue && more_data;
    assign rd_addr   = k_reg[WORD_AW+1:2];
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign sector_done = issue && !more_data && job_reg.uses_store;

    always_comb
    begin
        item = '0;
        item.sectors_done = job_reg.sectors;
        item.failure_code = OK_CODE;
        if (more_data)
        begin
            item.kind        = KIND_DATA;
            item.valid_bytes = nv;
            item.dest_offset = data_off;
            item.total_bytes = data_off + 16'(nv);
        end
        else
        begin
            item.kind           = KIND_STATUS;
            item.status         = job_reg.st;
            item.next_sector    = job_reg.next_sector;
            item.total_bytes    = job_reg.total;
            item.failing_sector = job_reg.failing;
            item.failure_code   = job_reg.code;
            item.last           = 1'b1;
        end
    end

    always_comb
    begin
        out_item = s1_reg;
        if (s1_reg.kind == KIND_DATA)
            out_item.data_word = rdata_reg & byte_mask(s1_reg.valid_bytes);
        else
            out_item.data_word = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_RUN;
                    k_next     = '0;
                end
            end
            S_RUN:
            begin
                if (issue)
                begin
                    if (more_data)
                        k_next = k_reg + 8'(WORD_BYTES);
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s1_valid_next  = issue ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = adv ? s1_valid_reg : out_valid_reg;

    // sector store: front writes, sequencer reads
    always_ff @(posedge clk)
    begin
        if (wr.en)
            store[wr.addr] <= wr.data;
        if (rd_en)
            rdata_reg <= store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_head;
        if (issue)
            s1_reg <= item;
        if (adv && s1_valid_reg)
            out_reg <= out_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_reg.kind;
    assign res.data_word      = out_reg.data_word;
    assign res.valid_bytes    = out_reg.valid_bytes;
    assign res.dest_offset    = out_reg.dest_offset;
    assign res.status         = out_reg.status;
    assign res.next_sector    = out_reg.next_sector;
    assign res.total_bytes    = out_reg.total_bytes;
    assign res.sectors_done   = out_reg.sectors_done;
    assign res.failing_sector = out_reg.failing_sector;
    assign res.failure_code   = out_reg.failure_code;
    assign res.last           = out_reg.last;

endmodule

`default_nettype wire

>>> rtl/dos2_file_chain_loader.sv
// dos2_file_chain_loader: top level of the sector chain loader
// depends on dfcl_pkg, dfcl_ifs, dfcl_front, dfcl_queue, dfcl_back
//
//   channel  dir  handshake      moves
//   cmd      in   valid/ready    open, sector word or read failure request
//   res      out  valid/ready    data word or sector status request
//
// the sector's last word closes the checks and queues a job. for a sector that
// passes, the back end then sends ceil(used/4) data words and one status at one
// per cycle while res.ready holds, through the store read and the output
// register. cmd.ready drops while the job queue is full or while a sector job
// still reads the store. rst_n clears all control state at once; the store
// needs no clearing because every sector rewrites it before it is read
`timescale 1ns / 1ps
`default_nettype none

module dos2_file_chain_loader #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dfcl_cmd_if.sink   cmd,
    dfcl_res_if.source res
);
    import dfcl_pkg::*;

    // front to queue
    logic push;
    job_t push_job;
    logic q_full;

    // queue to back
    logic q_pop;
    logic q_empty;
    job_t q_head;

    // store writes and sector release
    wr_t  wr;
    logic sector_done;

    // front end: file state, trailer checks, store writes
    dfcl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .q_full      (q_full),
        .sector_done (sector_done),
        .push        (push),
        .job         (push_job),
        .wr          (wr)
    );

    // decouples classification from result delivery
    dfcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end: store, result sequencer and output register
    dfcl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .sector_done (sector_done),
        .res         (res)
    );

endmodule

`default_nettype wire

>>> tb/tb_dos2_file_chain_loader.sv
// tb_dos2_file_chain_loader: self-checking bench for the sector chain loader
// drives cmd requests, predicts every res request and compares field by field
// depends on dfcl_pkg, dfcl_ifs and the dos2_file_chain_loader rtl
`timescale 1ns / 1ps

module tb_dos2_file_chain_loader;

    import dfcl_pkg::*;

    // command code the block has no use for
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int RANDOM_REQUESTS = 300;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int TAIL_CYCLES     = 40;

    // what the trailer of a generated sector asks for
    typedef enum {
        SEC_NEXT,
        SEC_WRONG_FILE,
        SEC_OVERSIZE,
        SEC_OVER_CAP,
        SEC_EXACT_CAP,
        SEC_LAST
    } sector_kind_t;

    // receiver back-pressure styles
    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY4,
        STALL_LONG
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    dfcl_cmd_if cmd_bus ();
    dfcl_res_if res_bus ();

    dos2_file_chain_loader i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predicted loader state, kept in step with accepted cmd requests
    // ------------------------------------------------------------------
    logic [31:0] sector_image [WORDS];
    int          word_slot;
    logic [15:0] chain_sector;
    logic [15:0] bytes_delivered;
    logic [15:0] sectors_read;
    logic        open_wide;
    logic [5:0]  open_file_no;
    logic [15:0] open_capacity;
    logic        file_open;

    // res requests still owed by the block, oldest first
    res_t results_due [$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned live_requests;
    int unsigned burst_left;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic res_t status_result(input logic [2:0] st, input logic [15:0] next_link,
                                           input logic [15:0] failing, input logic [7:0] code);
        res_t r;
        r                = '0;
        r.kind           = KIND_STATUS;
        r.status         = st;
        r.next_sector    = next_link;
        r.total_bytes    = bytes_delivered;
        r.sectors_done   = sectors_read;
        r.failing_sector = failing;
        r.failure_code   = code;
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic res_t data_result(input logic [31:0] w, input logic [2:0] nv,
                                         input logic [15:0] offset);
        res_t r;
        r              = '0;
        r.kind         = KIND_DATA;
        r.data_word    = w;
        r.valid_bytes  = nv;
        r.dest_offset  = offset;
        r.total_bytes  = offset + 16'(nv);
        r.sectors_done = sectors_read;
        r.failure_code = OK_CODE;
        return r;
    endfunction

    // trailer checks and data words once the last sector word is in
    task automatic close_sector();
        logic [7:0]  link_hi;
        logic [7:0]  link_lo;
        logic [7:0]  used;
        logic [15:0] next_link;
        logic [31:0] w;
        int          k;
        int          nv;
        link_hi = sector_image[WORDS-1][15:8];
        link_lo = sector_image[WORDS-1][23:16];
        used    = sector_image[WORDS-1][31:24] & BYTE_CNT_MASK;
        if (sectors_read != 16'hFFFF)
            sectors_read++;
        if (!open_wide && link_hi[7:2] != open_file_no)
        begin
            file_open = 1'b0;
            results_due.push_back(status_result(STAT_BAD_LINK, '0, chain_sector, OK_CODE));
        end
        else if (used > 8'(MAX_USED))
        begin
            file_open = 1'b0;
            results_due.push_back(status_result(STAT_BAD_LINK, '0, chain_sector, OK_CODE));
        end
        else if (17'(bytes_delivered) + 17'(used) > 17'(open_capacity))
        begin
            file_open = 1'b0;
            results_due.push_back(status_result(STAT_TOO_BIG, '0, '0, OK_CODE));
        end
        else
        begin
            for (k = 0; k < int'(used); k += 4)
            begin
                nv = (int'(used) - k >= 4) ? 4 : int'(used) - k;
                w  = sector_image[k / 4];
                if (nv < 4)
                    w &= (32'h1 << (nv * 8)) - 32'h1;
                results_due.push_back(data_result(w, 3'(nv), bytes_delivered + 16'(k)));
            end
            bytes_delivered = bytes_delivered + 16'(used);
            next_link = open_wide ? {link_hi, link_lo} : {link_hi & LINK_HI_MASK, link_lo};
            if (next_link == 16'h0)
            begin
                file_open = 1'b0;
                results_due.push_back(status_result(STAT_DONE, '0, '0, OK_CODE));
            end
            else
            begin
                chain_sector = next_link;
                results_due.push_back(status_result(STAT_NEXT, next_link, '0, OK_CODE));
            end
        end
    endtask

    task automatic predict_chain_step(input logic [1:0] op, input logic l16,
                                      input logic [5:0] fno, input logic [15:0] start,
                                      input logic [15:0] maxlen, input logic [31:0] word,
                                      input logic [7:0] rstat);
        if (op == CMD_OPEN)
        begin
            // a new open drops whatever file was in progress
            live_requests++;
            open_wide       = l16;
            open_file_no    = fno;
            chain_sector    = start;
            open_capacity   = maxlen;
            bytes_delivered = '0;
            sectors_read    = '0;
            word_slot       = 0;
            file_open       = (start != 16'h0);
            if (start == 16'h0)
                results_due.push_back(status_result(STAT_DONE, '0, '0, OK_CODE));
            else
                results_due.push_back(status_result(STAT_NEXT, start, '0, OK_CODE));
        end
        else if (file_open && op != CMD_NONE)
        begin
            live_requests++;
            if (op == CMD_FAIL)
            begin
                // partial sector is thrown away, any read code is passed on
                word_slot = 0;
                file_open = 1'b0;
                results_due.push_back(status_result(STAT_READ_ERR, '0, chain_sector, rstat));
            end
            else
            begin
                sector_image[word_slot] = word;
                if (word_slot == WORDS - 1)
                begin
                    word_slot = 0;
                    close_sector();
                end
                else
                    word_slot++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // cmd side: bursts of requests with random gaps in between
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic l16, input logic [5:0] fno,
                                input logic [15:0] start, input logic [15:0] maxlen,
                                input logic [31:0] word, input logic [7:0] rstat);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // a long stretch with no idling at all
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 8);
            end
            if (gap != 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= op;
        cmd_bus.link16_mode  <= l16;
        cmd_bus.file_number  <= fno;
        cmd_bus.start_sector <= start;
        cmd_bus.max_length   <= maxlen;
        cmd_bus.sector_word  <= word;
        cmd_bus.read_status  <= rstat;
        // ready is read before the edge takes effect, so this is the handshake
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predict_chain_step(op, l16, fno, start, maxlen, word, rstat);
    endtask

    // unused fields carry random values so every bit moves
    task automatic send_open(input logic l16, input logic [5:0] fno, input logic [15:0] start,
                             input logic [15:0] maxlen);
        send_request(CMD_OPEN, l16, fno, start, maxlen, $urandom, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_word(input logic [31:0] w);
        send_request(CMD_DATA, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), w,
                     8'($urandom_range(0, 255)));
    endtask

    task automatic send_failure(input logic [7:0] code);
        send_request(CMD_FAIL, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), $urandom,
                     code);
    endtask

    task automatic send_stray();
        send_request(CMD_NONE, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), $urandom,
                     8'($urandom_range(0, 255)));
    endtask

    // one 32-word sector with the given trailer; break_at cuts it short
    // with a read failure or a fresh open at that word
    task automatic send_sector(input logic [7:0] link_hi, input logic [7:0] link_lo,
                               input logic [7:0] used_byte, input int break_at,
                               input logic [1:0] break_op);
        logic [31:0] w;
        int          i;
        for (i = 0; i < WORDS; i++)
        begin
            if (i == break_at)
            begin
                if (break_op == CMD_FAIL)
                    send_failure(8'($urandom_range(0, 255)));
                else
                    send_open(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                              16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
                return;
            end
            if ($urandom_range(0, 39) == 0)
                send_stray();
            w = $urandom;
            if (i == WORDS - 1)
                w = {used_byte, link_lo, link_hi, w[7:0]};
            send_word(w);
        end
    endtask

    // hold the sender until the block has delivered everything owed
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // res side: stall pattern that changes style every so often
    // ------------------------------------------------------------------
    initial
    begin : res_stall_pattern
        stall_mode_t mode;
        int          left;
        res_bus.ready <= 1'b0;
        mode = STALL_NONE;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(30, 150);
            end
            left--;
            case (mode)
                STALL_NONE:   res_bus.ready <= 1'b1;
                STALL_COIN:   res_bus.ready <= 1'($urandom_range(0, 1));
                STALL_EVERY4: res_bus.ready <= (left % 4 == 0);
                default:      res_bus.ready <= (left % 24 < 3);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // every accepted res request is checked against the oldest prediction
    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.kind           = res_bus.kind;
            got.data_word      = res_bus.data_word;
            got.valid_bytes    = res_bus.valid_bytes;
            got.dest_offset    = res_bus.dest_offset;
            got.status         = res_bus.status;
            got.next_sector    = res_bus.next_sector;
            got.total_bytes    = res_bus.total_bytes;
            got.sectors_done   = res_bus.sectors_done;
            got.failing_sector = res_bus.failing_sector;
            got.failure_code   = res_bus.failure_code;
            got.last           = res_bus.last;
            if (results_due.size() == 0)
                report_mismatch("request with nothing expected, kind", got.kind, '0);
            else
            begin
                want = results_due.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", got.kind, want.kind);
                if (got.data_word !== want.data_word)
                    report_mismatch("data_word", got.data_word, want.data_word);
                if (got.valid_bytes !== want.valid_bytes)
                    report_mismatch("valid_bytes", got.valid_bytes, want.valid_bytes);
                if (got.dest_offset !== want.dest_offset)
                    report_mismatch("dest_offset", got.dest_offset, want.dest_offset);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.next_sector !== want.next_sector)
                    report_mismatch("next_sector", got.next_sector, want.next_sector);
                if (got.total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", got.total_bytes, want.total_bytes);
                if (got.sectors_done !== want.sectors_done)
                    report_mismatch("sectors_done", got.sectors_done, want.sectors_done);
                if (got.failing_sector !== want.failing_sector)
                    report_mismatch("failing_sector", got.failing_sector, want.failing_sector);
                if (got.failure_code !== want.failure_code)
                    report_mismatch("failure_code", got.failure_code, want.failure_code);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL dos2_file_chain_loader");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // nothing open: data words, read failures and the unused code are dropped
    task automatic test_ignored_requests();
        send_request(CMD_DATA, 1'b1, 6'h3F, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_FAIL, 1'b0, 6'h00, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
        send_request(CMD_NONE, 1'b1, 6'h3F, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_NONE, 1'b0, 6'h00, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00);
    endtask

    // opens at the field extremes, reopen mid-sector, read failures
    task automatic test_open_and_failure();
        // empty file answers done at once and stays closed
        send_open(1'b1, 6'h3F, 16'h0000, 16'hFFFF);
        send_word($urandom);
        send_open(1'b0, 6'h00, 16'hFFFF, 16'h0000);
        send_stray();
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        // reopen drops the partial sector
        send_open(1'b1, 6'h2A, 16'h0001, 16'h8000);
        send_word($urandom);
        send_failure(8'h00);
        // closed again, so this failure is ignored
        send_failure(8'h55);
        send_open(1'b0, 6'h15, 16'h8000, 16'h007D);
        send_failure(8'hFF);
        send_open(1'b0, 6'h3F, 16'h03FF, 16'hFFFF);
        send_failure(8'hAA);
    endtask

    // well-formed chains with random content; the trailer kinds rotate so
    // every outcome shows up, with failures and reopens cutting some sectors
    task automatic test_random_chains();
        sector_kind_t plan [8];
        sector_kind_t kind;
        int          plan_pos;
        int          goal;
        int          files;
        int          room;
        int          used;
        int          break_at;
        logic [15:0] cap;
        logic [15:0] next_link;
        logic [7:0]  link_hi;
        plan = '{SEC_NEXT, SEC_WRONG_FILE, SEC_NEXT, SEC_OVERSIZE, SEC_NEXT, SEC_OVER_CAP,
                 SEC_EXACT_CAP, SEC_LAST};
        plan_pos = 0;
        files    = 0;
        goal     = live_requests + RANDOM_REQUESTS;
        while (live_requests < goal || plan_pos < 8)
        begin
            files++;
            case ($urandom_range(0, 2))
                0:       cap = 16'hFFFF;
                1:       cap = 16'($urandom_range(0, 600));
                default: cap = 16'($urandom_range(0, 65535));
            endcase
            send_open($urandom_range(0, 99) < 35, 6'($urandom_range(0, 63)),
                      ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom_range(1, 65535)), cap);
            while (file_open)
            begin
                kind = plan[plan_pos % 8];
                room = int'(open_capacity) - int'(bytes_delivered);
                // capacity cases need a small room: reopen with a tight limit
                if ((kind == SEC_OVER_CAP && room > 124) || (kind == SEC_EXACT_CAP && room > 125))
                begin
                    send_open(open_wide, open_file_no, 16'($urandom_range(1, 65535)),
                              16'($urandom_range(0, (kind == SEC_OVER_CAP) ? 124 : 125)));
                    room = int'(open_capacity) - int'(bytes_delivered);
                end
                case (kind)
                    SEC_OVERSIZE:  used = $urandom_range(126, 127);
                    SEC_OVER_CAP:  used = room + 1;
                    SEC_EXACT_CAP: used = room;
                    default:
                    begin
                        case ($urandom_range(0, 2))
                            0:       used = $urandom_range(0, 125);
                            1:       used = $urandom_range(0, 5);
                            default: used = $urandom_range(120, 125);
                        endcase
                        if (used > room)
                            used = room;
                    end
                endcase
                if (kind == SEC_LAST)
                    next_link = 16'h0;
                else if (open_wide)
                    next_link = 16'($urandom_range(1, 65535));
                else
                    next_link = 16'($urandom_range(1, 1023));
                // wide links take the whole high byte, no file number check
                if (open_wide)
                    link_hi = next_link[15:8];
                else
                begin
                    link_hi = {open_file_no, next_link[9:8]};
                    if (kind == SEC_WRONG_FILE)
                        link_hi[7:2] = open_file_no ^ 6'($urandom_range(1, 63));
                end
                break_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, WORDS - 1) : -1;
                send_sector(link_hi, next_link[7:0], {1'($urandom_range(0, 1)), 7'(used)},
                            break_at, $urandom_range(0, 1) ? CMD_FAIL : CMD_OPEN);
                if (break_at < 0)
                    plan_pos++;
            end
            // stray requests after the file closed are dropped
            if ($urandom_range(0, 3) == 0)
                send_word($urandom);
            if ($urandom_range(0, 5) == 0)
                send_failure(8'($urandom_range(0, 255)));
            // first file ends with the sender held until all results are in
            if (files == 1 || $urandom_range(0, 7) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.command      <= CMD_OPEN;
        cmd_bus.link16_mode  <= 1'b0;
        cmd_bus.file_number  <= '0;
        cmd_bus.start_sector <= '0;
        cmd_bus.max_length   <= '0;
        cmd_bus.sector_word  <= '0;
        cmd_bus.read_status  <= '0;
        word_slot       = 0;
        chain_sector    = '0;
        bytes_delivered = '0;
        sectors_read    = '0;
        open_wide       = 1'b0;
        open_file_no    = '0;
        open_capacity   = '0;
        file_open       = 1'b0;
        mismatches      = 0;
        results_seen    = 0;
        live_requests   = 0;
        burst_left      = 0;
        cycle_count     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_requests();
        test_open_and_failure();
        test_random_chains();

        // everything owed has to arrive, then watch for extra requests
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS dos2_file_chain_loader");
        else
            $display("FAIL dos2_file_chain_loader");
        $finish;
    end

endmodule

>>> files.f
rtl/dfcl_pkg.sv
rtl/dfcl_ifs.sv
rtl/dfcl_front.sv
rtl/dfcl_queue.sv
rtl/dfcl_back.sv
rtl/dos2_file_chain_loader.sv
tb/tb_dos2_file_chain_loader.sv
